@@ rtl/toy_register_memory_cpu_execute_top_assert.svh @@
// Assertion macros for the execute block
`ifndef TOY_REGISTER_MEMORY_CPU_EXECUTE_TOP_ASSERT_SVH
`define TOY_REGISTER_MEMORY_CPU_EXECUTE_TOP_ASSERT_SVH

`define TRM_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

`define TRM_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

@@ rtl/trmce_pkg.sv @@
`default_nettype none
package trmce_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned AddrW = 16;

  typedef enum logic [2:0] {
    OP_MOV = 3'd0,
    OP_ADD = 3'd1,
    OP_SUB = 3'd2,
    OP_MUL = 3'd3,
    OP_DIV = 3'd4,
    OP_HLT = 3'd5,
    OP_UNK = 3'd6,
    OP_UN7 = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    K_REG = 2'd0,
    K_MEM = 2'd1,
    K_IMM = 2'd2,
    K_IM3 = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_DIVZERO = 3'd1,
    ST_UNKNOWN = 3'd2,
    ST_HALTNOW = 3'd3,
    ST_REFUSED = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0]        op;
    logic [1:0]        a_kind;
    logic [1:0]        a_reg;
    logic [AddrW-1:0]  a_addr;
    logic signed [DataW-1:0] a_imm;
    logic [1:0]        b_kind;
    logic [1:0]        b_reg;
    logic [AddrW-1:0]  b_addr;
    logic signed [DataW-1:0] b_imm;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]        status;
    logic signed [DataW-1:0] ax_value;
    logic signed [DataW-1:0] bx_value;
    logic signed [DataW-1:0] cx_value;
    logic signed [DataW-1:0] dx_value;
    logic              mem_write;
    logic [AddrW-1:0]  mem_addr;
    logic signed [DataW-1:0] mem_value;
  } out_beat_t;

endpackage
`default_nettype wire

@@ rtl/toy_register_memory_cpu_execute_top.sv @@
// Channel   Handshake            Payload
// in        in_valid_i/ready_o   in_data_i  (in_beat_t)
// out       out_valid_o/ready_i  out_data_o (out_beat_t)
// States per item: IDLE, RDA, RDB, EXEC, OUT; a DIV by nonzero adds DIV (restoring divider).
// Reset clears registers and the halt flag, then a clearing pass writes zero to
// all MEM_WORDS words of data memory; the back end takes no item during it.
// A two-entry queue lets the input side take beats while the back end runs.
// The back end takes the next item only once the waiting result beat is taken.
`default_nettype none
module toy_register_memory_cpu_execute_top
  import trmce_pkg::*;
#(
  parameter int unsigned MEM_WORDS = 65536
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_beat_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_beat_t      out_data_o
);

  logic     q_valid, q_ready;
  in_beat_t q_data;

  trmce_front #(.Depth(2)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_data_o  (q_data)
  );

  trmce_back #(.MemWords(MEM_WORDS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_ready_o  (q_ready),
    .q_data_i   (q_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire

@@ rtl/trmce_front.sv @@
`default_nettype none
module trmce_front
  import trmce_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_beat_t in_data_i,
  output logic          q_valid_o,
  input  wire logic     q_ready_i,
  output in_beat_t      q_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  in_beat_t        fifo_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign in_ready_o = (cnt_q != CntW'(Depth));
  assign q_valid_o  = (cnt_q != '0);
  assign q_data_o   = fifo_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/trmce_div.sv @@
`default_nettype none
module trmce_div
  import trmce_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DataW-1:0] num_i,
  input  wire logic [DataW-1:0] den_i,
  output logic                  done_o,
  output logic [DataW-1:0]      quot_o
);

  localparam int unsigned CntW = $clog2(DataW + 1);

  logic [DataW-1:0] ua_q, ub_q, rem_q, quo_q;
  logic             neg_q, busy_q;
  logic [CntW-1:0]  cnt_q;
  logic [DataW:0]   trial;
  logic [DataW-1:0] shifted;

  assign shifted = {rem_q[DataW-2:0], ua_q[DataW-1]};
  assign trial   = {1'b0, shifted} - {1'b0, ub_q};
  assign done_o  = busy_q && (cnt_q == '0);
  assign quot_o  = neg_q ? (DataW'(0) - quo_q) : quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ua_q  <= num_i[DataW-1] ? (DataW'(0) - num_i) : num_i;
      ub_q  <= den_i[DataW-1] ? (DataW'(0) - den_i) : den_i;
      neg_q <= num_i[DataW-1] ^ den_i[DataW-1];
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q && cnt_q != '0) begin
      ua_q <= {ua_q[DataW-2:0], 1'b0};
      if (!trial[DataW]) begin
        rem_q <= trial[DataW-1:0];
        quo_q <= {quo_q[DataW-2:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quo_q <= {quo_q[DataW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(DataW);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/trmce_back.sv @@
`default_nettype none
module trmce_back
  import trmce_pkg::*;
#(
  parameter int unsigned MemWords = 65536
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     q_valid_i,
  output logic          q_ready_o,
  input  wire in_beat_t q_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output out_beat_t     out_data_o
);

  localparam int unsigned MemAw = $clog2(MemWords);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_RDA   = 7'b0000100,
    S_RDB   = 7'b0001000,
    S_EXEC  = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [DataW-1:0] mem_q [MemWords];
  logic [DataW-1:0] rd_data_q;
  logic [MemAw-1:0] rd_addr, clr_q;
  logic [DataW-1:0] regs_q [4];
  logic [DataW-1:0] x_q, y_q, prod_q;
  logic             halted_q;
  in_beat_t         cur_q;
  out_beat_t        out_q;
  logic             out_valid_q;
  logic             mem_we;
  logic [MemAw-1:0] mem_wa;
  logic [DataW-1:0] mem_wd;
  logic             div_start, div_done;
  logic [DataW-1:0] div_quot;
  logic [DataW-1:0] a_val, b_val;

  trmce_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (x_q),
    .den_i  (y_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign q_ready_o   = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    rd_addr = q_data_i.a_addr[MemAw-1:0];
    if (state_q == S_RDA) begin
      rd_addr = cur_q.b_addr[MemAw-1:0];
    end
  end

  always_comb begin
    case (kind_e'(cur_q.a_kind))
      K_REG:   a_val = regs_q[cur_q.a_reg];
      K_MEM:   a_val = rd_data_q;
      default: a_val = cur_q.a_imm;
    endcase
  end

  always_comb begin
    case (kind_e'(cur_q.b_kind))
      K_REG:   b_val = regs_q[cur_q.b_reg];
      K_MEM:   b_val = rd_data_q;
      default: b_val = cur_q.b_imm;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_q;
    mem_wd = '0;
    if (state_q == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state_q == S_EXEC && !halted_q && op_e'(cur_q.op) == OP_MOV
                 && kind_e'(cur_q.a_kind) == K_MEM) begin
      mem_we = 1'b1;
      mem_wa = cur_q.a_addr[MemAw-1:0];
      mem_wd = y_q;
    end
  end

  assign div_start = (state_q == S_EXEC) && !halted_q && (op_e'(cur_q.op) == OP_DIV)
                     && (y_q != '0);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (q_valid_i && q_ready_o) begin
      cur_q <= q_data_i;
    end
    if (state_q == S_RDA) begin
      x_q <= a_val;
    end
    if (state_q == S_RDB) begin
      y_q    <= b_val;
      prod_q <= x_q * b_val;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == MemAw'(MemWords - 1)) state_d = S_IDLE;
      S_IDLE:  if (q_valid_i && q_ready_o) state_d = S_RDA;
      S_RDA:   state_d = S_RDB;
      S_RDB:   state_d = S_EXEC;
      S_EXEC:  state_d = div_start ? S_DIV : S_OUT;
      S_DIV:   if (div_done) state_d = S_OUT;
      S_OUT:   if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        regs_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_EXEC) begin
        out_q.status    <= ST_DONE;
        out_q.mem_write <= 1'b0;
        out_q.mem_addr  <= '0;
        out_q.mem_value <= '0;
        if (halted_q) begin
          out_q.status <= ST_REFUSED;
        end else begin
          case (op_e'(cur_q.op))
            OP_HLT: begin
              halted_q     <= 1'b1;
              out_q.status <= ST_HALTNOW;
            end
            OP_MOV: begin
              if (kind_e'(cur_q.a_kind) == K_REG) begin
                regs_q[cur_q.a_reg] <= y_q;
              end else if (kind_e'(cur_q.a_kind) == K_MEM) begin
                out_q.mem_write <= 1'b1;
                out_q.mem_addr  <= AddrW'(cur_q.a_addr[MemAw-1:0]);
                out_q.mem_value <= y_q;
              end
            end
            OP_ADD: regs_q[0] <= x_q + y_q;
            OP_SUB: regs_q[0] <= x_q - y_q;
            OP_MUL: regs_q[0] <= prod_q;
            OP_DIV: if (y_q == '0) out_q.status <= ST_DIVZERO;
            default: out_q.status <= ST_UNKNOWN;
          endcase
        end
      end
      if (state_q == S_DIV && div_done) begin
        regs_q[0] <= div_quot;
      end
      if (state_q == S_OUT && (!out_valid_q || out_ready_i)) begin
        out_valid_q    <= 1'b1;
        out_q.ax_value <= regs_q[0];
        out_q.bx_value <= regs_q[1];
        out_q.cx_value <= regs_q[2];
        out_q.dx_value <= regs_q[3];
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/trmce_checker.sv @@
`default_nettype none
`include "toy_register_memory_cpu_execute_top_assert.svh"
module trmce_checker
  import trmce_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire in_beat_t  in_data_i,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_beat_t out_data_o
);

  `TRM_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_i && !in_ready_o,
    in_valid_i && $stable(in_data_i))
  `TRM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_data_o))
  `TRM_ASSERT_IMP(a_status_range, clk_i, rst_ni, out_valid_o, out_data_o.status <= ST_REFUSED)
  `TRM_ASSERT_IMP(a_nowrite_zero, clk_i, rst_ni, out_valid_o && !out_data_o.mem_write,
    out_data_o.mem_addr == '0 && out_data_o.mem_value == '0)
  `TRM_ASSERT_NEXT(a_halt_sticky, clk_i, rst_ni,
    out_valid_o && out_ready_i && out_data_o.status == ST_HALTNOW,
    !out_valid_o || out_data_o.status == ST_REFUSED)

endmodule

bind toy_register_memory_cpu_execute_top trmce_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
`default_nettype wire
